/* rtl/t8ctc_pkg.sv */
// Shared types, codes and the prescaler tap table for the 8-bit timer/counter.
// Used by the step logic, the top level and the port checker.
package t8ctc_pkg;

  localparam int unsigned CountW    = 8;
  localparam int unsigned PrescaleW = 10;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 3;

  // Item kinds carried in the mode field; code 3 is a no-op.
  typedef enum logic [1:0] {
    ITEM_TICK  = 2'd0,
    ITEM_WRITE = 2'd1,
    ITEM_READ  = 2'd2
  } item_mode_e;

  typedef enum logic [1:0] {
    SEL_COUNT   = 2'd0,
    SEL_COMPARE = 2'd1,
    SEL_FLAGS   = 2'd2,
    SEL_ENABLES = 2'd3
  } reg_sel_e;

  // Waveform code 3 behaves as normal mode.
  typedef enum logic [1:0] {
    WAVE_NORMAL = 2'd0,
    WAVE_CTC    = 2'd1,
    WAVE_PWM    = 2'd2
  } wave_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CLOCK_SELECT  = 2'd0,
    CFG_WAVEFORM_MODE = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        reg_sel;
    logic [CountW-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] read_data;
    logic              overflow_flag;
    logic              compare_flag;
    logic              irq_overflow;
    logic              irq_compare;
    logic              pwm_level;
  } out_word_t;

  typedef struct packed {
    logic [2:0] clock_select;
    logic [1:0] waveform_mode;
  } cfg_t;

  // flags / enables: bit0 overflow, bit1 compare
  typedef struct packed {
    logic [PrescaleW-1:0] prescale_count;
    logic [CountW-1:0]    count_value;
    logic [CountW-1:0]    compare_value;
    logic [CountW-1:0]    compare_buffer;
    logic [1:0]           flag_bits;
    logic [1:0]           irq_enables;
    logic                 wave_level;
  } state_t;

  // Prescaler bits that must be zero for the counter to step.
  function automatic logic [PrescaleW-1:0] divide_mask(input logic [2:0] cs);
    logic [PrescaleW-1:0] m;
    case (cs)
      3'd2:    m = 10'd7;
      3'd3:    m = 10'd31;
      3'd4:    m = 10'd63;
      3'd5:    m = 10'd127;
      3'd6:    m = 10'd255;
      3'd7:    m = 10'd1023;
      default: m = 10'd0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/t8ctc_step.sv */
// Next-state and result logic for one word of the timer/counter.
// Purely combinational; depends on t8ctc_pkg.
module t8ctc_step (
  input  t8ctc_pkg::cfg_t     cfg_i,
  input  t8ctc_pkg::state_t   st_i,
  input  t8ctc_pkg::in_word_t word_i,
  output t8ctc_pkg::state_t   st_o,
  output t8ctc_pkg::out_word_t res_o
);
  import t8ctc_pkg::*;

  logic                 pwm_mode;
  logic [CountW-1:0]    cmp_act;
  logic [PrescaleW-1:0] ps_inc;
  logic                 hit;
  logic                 top;
  logic [CountW-1:0]    cnt_inc;
  logic [CountW-1:0]    rd;
  state_t               st;

  assign pwm_mode = (cfg_i.waveform_mode == WAVE_PWM);
  // outside fast PWM the active compare tracks the buffer directly
  assign cmp_act  = pwm_mode ? st_i.compare_value : st_i.compare_buffer;
  assign ps_inc   = st_i.prescale_count + PrescaleW'(1);
  assign hit      = (st_i.count_value == cmp_act);
  assign top      = (st_i.count_value == {CountW{1'b1}});
  assign cnt_inc  = st_i.count_value + CountW'(1);

  always_comb begin
    st               = st_i;
    st.compare_value = cmp_act;
    rd               = '0;
    case (word_i.mode)
      ITEM_TICK: begin
        if (cfg_i.clock_select != 3'd0) begin
          st.prescale_count = ps_inc;
          if ((ps_inc & divide_mask(cfg_i.clock_select)) == '0) begin
            case (cfg_i.waveform_mode)
              WAVE_PWM: begin
                if (hit) begin
                  st.flag_bits[1] = 1'b1;
                  st.wave_level   = 1'b0;
                end
                if (top) begin
                  st.count_value   = '0;
                  st.flag_bits[0]  = 1'b1;
                  st.compare_value = st_i.compare_buffer;
                  st.wave_level    = 1'b1;
                end else begin
                  st.count_value = cnt_inc;
                end
              end
              WAVE_CTC: begin
                if (hit) begin
                  st.flag_bits[1] = 1'b1;
                  st.count_value  = '0;
                end else if (top) begin
                  st.count_value  = '0;
                  st.flag_bits[0] = 1'b1;
                end else begin
                  st.count_value = cnt_inc;
                end
              end
              default: begin
                if (hit) st.flag_bits[1] = 1'b1;
                if (top) begin
                  st.count_value  = '0;
                  st.flag_bits[0] = 1'b1;
                end else begin
                  st.count_value = cnt_inc;
                end
              end
            endcase
          end
        end
      end
      ITEM_WRITE: begin
        case (word_i.reg_sel)
          SEL_COUNT: st.count_value = word_i.write_data;
          SEL_COMPARE: begin
            st.compare_buffer = word_i.write_data;
            if (!pwm_mode) st.compare_value = word_i.write_data;
          end
          SEL_FLAGS: st.flag_bits = st_i.flag_bits & ~word_i.write_data[1:0];
          default:   st.irq_enables = word_i.write_data[1:0];
        endcase
      end
      ITEM_READ: begin
        case (word_i.reg_sel)
          SEL_COUNT:   rd = st_i.count_value;
          SEL_COMPARE: rd = st_i.compare_buffer;
          SEL_FLAGS:   rd = {{(CountW-2){1'b0}}, st_i.flag_bits};
          default:     rd = {{(CountW-2){1'b0}}, st_i.irq_enables};
        endcase
      end
      default: ;
    endcase
  end

  assign st_o                = st;
  assign res_o.read_data     = rd;
  assign res_o.overflow_flag = st.flag_bits[0];
  assign res_o.compare_flag  = st.flag_bits[1];
  assign res_o.irq_overflow  = st.flag_bits[0] & st.irq_enables[0];
  assign res_o.irq_compare   = st.flag_bits[1] & st.irq_enables[1];
  assign res_o.pwm_level     = pwm_mode & st.wave_level;

endmodule

/* rtl/timer8_ctc_fast_pwm_unit.sv */
// Top level of the 8-bit timer/counter with compare and fast PWM.
// Instantiates t8ctc_step; types and codes come from t8ctc_pkg.

// One word in, one word out. Each input word is a clock tick, a register write
// or a register read; it is applied to the timer state in the cycle it is
// accepted and its result word (read data, flags, interrupt lines, PWM level)
// is registered in the result register, or in the skid while the output is
// stalled. A new word is accepted every cycle unless in_stall_o is high:
// throughput is one word per clock while the input is not stalled. A two-entry
// output queue (result register plus skid) lets the input keep flowing while
// the output is stalled; in_stall_o rises only when both entries are full.
// Configuration (clock select at index 0, waveform mode at index 1) is always
// ready and must only be written while no word is in flight. Prescaler taps:
// /1,/8,/32,/64,/128,/256,/1024; clock select 0 stops the timer.
module timer8_ctc_fast_pwm_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  t8ctc_pkg::in_word_t              in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output t8ctc_pkg::out_word_t             out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [t8ctc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [t8ctc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import t8ctc_pkg::*;

  cfg_t      cfg_q;
  state_t    st_q, st_d;
  out_word_t res;

  // output queue
  out_word_t out_q, out_d, skid_q, skid_d;
  logic      out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic      accept, out_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLOCK_SELECT:  cfg_q.clock_select  <= cfg_data_i;
        CFG_WAVEFORM_MODE: cfg_q.waveform_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign accept  = in_valid_i & ~skid_vld_q;
  assign out_pop = out_vld_q & ~out_stall_i;

  t8ctc_step u_step (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .word_i (in_word_i),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // Result register refills from the skid first, else from the new word.
  // While the skid is full no word is accepted, so it simply drains.
  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_pop) begin
      out_d      = skid_vld_q ? skid_q : res;
      out_vld_d  = skid_vld_q | accept;
      skid_vld_d = 1'b0;
    end else if (accept) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/t8ctc_checker.sv */
// Port-level checks for timer8_ctc_fast_pwm_unit, bound to the top level.
// Depends on t8ctc_pkg for the word types.
module t8ctc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input t8ctc_pkg::out_word_t out_word_o
);
  import t8ctc_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a word accepted into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // input only backs up after the output was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // interrupt lines never fire without their flag
  a_irq_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_word_o.irq_overflow || out_word_o.overflow_flag) &&
                    (!out_word_o.irq_compare || out_word_o.compare_flag))
    else $error("interrupt without flag");

endmodule

bind timer8_ctc_fast_pwm_unit t8ctc_checker u_t8ctc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
